// ===== design/hmbd_pkg.sv =====
package hmbd_pkg;

  // bus operation codes
  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_PRELOAD = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // where an access is routed
  typedef enum logic [1:0] {
    TGT_INTERNAL = 2'd0,
    TGT_CART_ROM = 2'd1,
    TGT_CART_RAM = 2'd2,
    TGT_SPARE    = 2'd3
  } target_t;

  // sequencer states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // memory map boundaries
  localparam logic [15:0] ADDR_BOOT_END  = 16'h00FF;
  localparam logic [15:0] ADDR_ROM_END   = 16'h7FFF;
  localparam logic [15:0] ADDR_VRAM_LO   = 16'h8000;
  localparam logic [15:0] ADDR_VRAM_HI   = 16'h9FFF;
  localparam logic [15:0] ADDR_CRAM_LO   = 16'hA000;
  localparam logic [15:0] ADDR_CRAM_HI   = 16'hBFFF;
  localparam logic [15:0] ADDR_ECHO_LO   = 16'hE000;
  localparam logic [15:0] ADDR_ECHO_HI   = 16'hFDFF;
  localparam logic [15:0] ADDR_OAM_LO    = 16'hFE00;
  localparam logic [15:0] ADDR_OAM_HI    = 16'hFEFF;
  localparam logic [15:0] ECHO_OFFSET    = 16'h2000;

  // hardware registers
  localparam logic [15:0] REG_JOYP = 16'hFF00;
  localparam logic [15:0] REG_SC   = 16'hFF02;
  localparam logic [15:0] REG_DIV  = 16'hFF04;
  localparam logic [15:0] REG_TAC  = 16'hFF07;
  localparam logic [15:0] REG_IF   = 16'hFF0F;
  localparam logic [15:0] REG_NR14 = 16'hFF14;
  localparam logic [15:0] REG_NR24 = 16'hFF19;
  localparam logic [15:0] REG_NR34 = 16'hFF1E;
  localparam logic [15:0] REG_NR44 = 16'hFF23;
  localparam logic [15:0] REG_LCDC = 16'hFF40;
  localparam logic [15:0] REG_DMA  = 16'hFF46;
  localparam logic [15:0] REG_BOOT = 16'hFF50;
  localparam logic [15:0] REG_IE   = 16'hFFFF;

  // register bit masks
  localparam logic [7:0] SC_FIXED    = 8'h7C;
  localparam logic [7:0] SC_MASK     = 8'h81;
  localparam logic [7:0] TAC_FIXED   = 8'hF8;
  localparam logic [7:0] TAC_MASK    = 8'h07;
  localparam logic [7:0] IRQ_KEEP    = 8'hE0;
  localparam logic [7:0] IRQ_MASK    = 8'h1F;
  localparam logic [7:0] JOYP_SEL    = 8'h30;
  localparam logic [7:0] JOYP_KEEP   = 8'hC0;
  localparam logic [7:0] NRX4_UNUSED = 8'h38;
  localparam logic [7:0] BYTE_ONES   = 8'hFF;

  // audio channel numbers
  localparam logic [2:0] CH_NONE = 3'd0;
  localparam logic [2:0] CH_1    = 3'd1;
  localparam logic [2:0] CH_2    = 3'd2;
  localparam logic [2:0] CH_3    = 3'd3;
  localparam logic [2:0] CH_4    = 3'd4;

  // one bus request
  typedef struct packed {
    op_t         op;
    logic [15:0] address;
    logic [7:0]  data;
    logic        vram_busy;
    logic        oam_busy;
    logic [3:0]  pad_directions;
    logic [3:0]  pad_actions;
  } req_t;

  // one answer
  typedef struct packed {
    logic       video_reset;
    logic       divider_reset;
    logic [7:0] dma_page;
    logic       dma_start;
    logic       audio_length_enable;
    logic       audio_trigger;
    logic [2:0] audio_channel;
    logic [7:0] read_data;
  } result_t;

  // store write port
  typedef struct packed {
    logic        en;
    logic [15:0] addr;
    logic [7:0]  data;
  } wr_t;

endpackage

// ===== design/handheld_memory_bus_decoder.sv =====
// Memory map decoder for a handheld console bus. Each request is one byte access
// (read, decoded write or raw preload) to a 64K byte store held in one
// synchronous RAM; the unused op code gets an all-zero answer. The store is read
// at the accepted edge and the answer is formed, written back and placed in the
// output register in the decode state that follows. The block takes no new
// request until the last one is committed; a stalled result holds the next
// request in its decode cycle. The boot lock register lives in a flip-flop that
// reset clears; every other store entry is undefined until written by a preload or a decoded write.
module handheld_memory_bus_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // address[15:0], data[23:16], vram_busy[24], oam_busy[25],
  // pad_directions[29:26], pad_actions[33:30], zero[39:34]
  input  logic [39:0] s_tdata,
  // op[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data[7:0], audio_channel[10:8], audio_trigger[11],
  // audio_length_enable[12], dma_start[13], dma_page[21:14],
  // divider_reset[22], video_reset[23]
  output logic [23:0] m_tdata,
  // target[1:0]
  output logic [1:0]  m_tuser
);
  import hmbd_pkg::*;

  state_t      state;
  state_t      state_next;
  req_t        req;
  req_t        in_req;
  logic [15:0] rd_addr;
  logic [7:0]  rd_data;
  logic [7:0]  boot;
  logic        accept;
  logic        stall;
  logic        commit;
  result_t     res;
  target_t     target;
  wr_t         dec_wr;
  wr_t         mem_wr;
  logic        boot_we;
  logic [7:0]  boot_data;

  // unpack the incoming request
  assign in_req.op             = op_t'(s_tuser);
  assign in_req.address        = s_tdata[15:0];
  assign in_req.data           = s_tdata[23:16];
  assign in_req.vram_busy      = s_tdata[24];
  assign in_req.oam_busy       = s_tdata[25];
  assign in_req.pad_directions = s_tdata[29:26];
  assign in_req.pad_actions    = s_tdata[33:30];

  // echo area reads its mirror
  assign rd_addr = ((in_req.address >= ADDR_ECHO_LO) && (in_req.address <= ADDR_ECHO_HI))
                   ? (in_req.address - ECHO_OFFSET) : in_req.address;

  assign accept = s_tvalid && s_tready;
  assign stall  = m_tvalid && !m_tready;

  // sequencer
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    commit     = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stall) begin
          commit     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= in_req;
    end
  end

  // byte store
  assign mem_wr.en   = dec_wr.en && commit;
  assign mem_wr.addr = dec_wr.addr;
  assign mem_wr.data = dec_wr.data;

  hmbd_store u_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (mem_wr)
  );

  hmbd_decode u_decode (
    .req       (req),
    .old_byte  (rd_data),
    .boot      (boot),
    .res       (res),
    .target    (target),
    .wr        (dec_wr),
    .boot_we   (boot_we),
    .boot_data (boot_data)
  );

  // boot lock register
  always_ff @(posedge clk) begin
    if (rst) begin
      boot <= '0;
    end else if (commit && boot_we) begin
      boot <= boot_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= res;
      m_tuser <= target;
    end
  end

  // store is only written in the decode cycle once the output is free
  a_write_in_exec: assert property (@(posedge clk) disable iff (rst)
    mem_wr.en |-> (state == S_EXEC) && !stall)
    else $error("store write outside decode cycle");

  // an accepted request is decoded in the next cycle
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("accepted request not decoded");

  // a fresh result only follows a decode cycle
  a_result_after_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_EXEC))
    else $error("result without decode");

endmodule

// ===== design/hmbd_store.sv =====
module hmbd_store (
  input  logic           clk,
  input  logic           rd_en,
  input  logic [15:0]    rd_addr,
  output logic [7:0]     rd_data,
  input  hmbd_pkg::wr_t  wr
);
  import hmbd_pkg::*;

  logic [7:0] mem [0:65535];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/hmbd_decode.sv =====
module hmbd_decode (
  input  hmbd_pkg::req_t     req,
  input  logic [7:0]         old_byte,
  input  logic [7:0]         boot,
  output hmbd_pkg::result_t  res,
  output hmbd_pkg::target_t  target,
  output hmbd_pkg::wr_t      wr,
  output logic               boot_we,
  output logic [7:0]         boot_data
);
  import hmbd_pkg::*;

  logic [15:0] a;
  logic [7:0]  v;
  logic        in_vram;
  logic        in_cram;
  logic        in_echo;
  logic        in_oam;
  logic        in_boot;
  logic [3:0]  pad_lo;

  assign a = req.address;
  assign v = req.data;

  // region tests
  assign in_vram = (a >= ADDR_VRAM_LO) && (a <= ADDR_VRAM_HI);
  assign in_cram = (a >= ADDR_CRAM_LO) && (a <= ADDR_CRAM_HI);
  assign in_echo = (a >= ADDR_ECHO_LO) && (a <= ADDR_ECHO_HI);
  assign in_oam  = (a >= ADDR_OAM_LO) && (a <= ADDR_OAM_HI);
  assign in_boot = !boot[0] && (a <= ADDR_BOOT_END);

  // joypad nibble selected by the written select bits
  always_comb begin
    priority if (!v[4]) begin
      pad_lo = req.pad_directions;
    end else if (!v[5]) begin
      pad_lo = req.pad_actions;
    end else begin
      pad_lo = 4'hF;
    end
  end

  // read and write rules
  always_comb begin
    res       = '0;
    target    = TGT_INTERNAL;
    wr.en     = 1'b0;
    wr.addr   = a;
    wr.data   = v;
    boot_we   = 1'b0;
    boot_data = v;
    unique case (req.op)
      OP_READ: begin
        priority if (in_boot) begin
          res.read_data = old_byte;
        end else if (a <= ADDR_ROM_END) begin
          target = TGT_CART_ROM;
        end else if (in_cram) begin
          target = TGT_CART_RAM;
        end else if (in_vram) begin
          res.read_data = req.vram_busy ? BYTE_ONES : old_byte;
        end else if (in_echo) begin
          res.read_data = old_byte;
        end else if (in_oam) begin
          res.read_data = req.oam_busy ? BYTE_ONES : old_byte;
        end else if (a == REG_JOYP) begin
          res.read_data = ((old_byte & JOYP_SEL) == JOYP_SEL) ? (old_byte | 8'h0F) : old_byte;
        end else if (a == REG_BOOT) begin
          res.read_data = boot;
        end else begin
          res.read_data = old_byte;
        end
      end
      OP_PRELOAD: begin
        if (a == REG_BOOT) begin
          boot_we = 1'b1;
        end else begin
          wr.en = 1'b1;
        end
      end
      OP_WRITE: begin
        priority if (a <= ADDR_ROM_END) begin
          target = TGT_CART_ROM;
        end else if (in_vram) begin
          wr.en = !req.vram_busy;
        end else if (in_cram) begin
          target = TGT_CART_RAM;
        end else if (in_echo) begin
          wr.en   = 1'b1;
          wr.addr = a - ECHO_OFFSET;
        end else if (in_oam) begin
          wr.en = !req.oam_busy;
        end else if (a == REG_JOYP) begin
          wr.en   = 1'b1;
          wr.data = {4'h0, pad_lo} | (v & JOYP_SEL) | (old_byte & JOYP_KEEP);
        end else if (a == REG_SC) begin
          wr.en   = 1'b1;
          wr.data = SC_FIXED | (v & SC_MASK);
        end else if (a == REG_DIV) begin
          wr.en             = 1'b1;
          wr.data           = '0;
          res.divider_reset = 1'b1;
        end else if (a == REG_TAC) begin
          wr.en   = 1'b1;
          wr.data = TAC_FIXED | (v & TAC_MASK);
        end else if (a == REG_IF || a == REG_IE) begin
          wr.en   = 1'b1;
          wr.data = (old_byte & IRQ_KEEP) | (v & IRQ_MASK);
        end else if (a == REG_NR14 || a == REG_NR24 || a == REG_NR34 || a == REG_NR44) begin
          wr.en                   = 1'b1;
          wr.data                 = v & ~NRX4_UNUSED;
          res.audio_trigger       = v[7];
          res.audio_length_enable = v[6];
          priority if (a == REG_NR14) begin
            res.audio_channel = CH_1;
          end else if (a == REG_NR24) begin
            res.audio_channel = CH_2;
          end else if (a == REG_NR34) begin
            res.audio_channel = CH_3;
          end else begin
            res.audio_channel = CH_4;
          end
        end else if (a == REG_LCDC) begin
          wr.en           = 1'b1;
          res.video_reset = !v[7];
        end else if (a == REG_DMA) begin
          res.dma_start = 1'b1;
          res.dma_page  = v;
        end else if (a == REG_BOOT) begin
          boot_we = !boot[0];
        end else begin
          wr.en = 1'b1;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

// ===== tb/sv/bus_decoder_checker.sv =====
`timescale 1ns / 1ps

// watches both stream channels, predicts each answer from a private copy of the
// byte store and compares the answers in order
module bus_decoder_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // address[15:0], data[23:16], vram_busy[24], oam_busy[25],
  // pad_directions[29:26], pad_actions[33:30], zero[39:34]
  input  logic [39:0] s_tdata,
  // op[1:0]
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // read_data[7:0], audio_channel[10:8], audio_trigger[11],
  // audio_length_enable[12], dma_start[13], dma_page[21:14],
  // divider_reset[22], video_reset[23]
  input  logic [23:0] m_tdata,
  // target[1:0]
  input  logic [1:0]  m_tuser,
  output int          mismatches,
  output int          outstanding
);
  import hmbd_pkg::*;

  typedef struct packed {
    target_t target;
    result_t fields;
  } answer_t;

  logic [7:0] mirror [0:65535];
  answer_t    expected_answers [$];
  int         fail_count = 0;

  // decode one bus request against the mirrored store
  function automatic answer_t decode_access(input op_t op, input logic [15:0] a,
                                            input logic [7:0] d, input logic vl,
                                            input logic ol, input logic [3:0] pd,
                                            input logic [3:0] pa);
    answer_t    ans;
    logic [7:0] sel;
    logic [3:0] low;
    ans = '0;
    case (op)
      OP_READ: begin
        if (!mirror[REG_BOOT][0] && a <= ADDR_BOOT_END) begin
          ans.fields.read_data = mirror[a];
        end else if (a <= ADDR_ROM_END) begin
          ans.target = TGT_CART_ROM;
        end else if (a >= ADDR_CRAM_LO && a <= ADDR_CRAM_HI) begin
          ans.target = TGT_CART_RAM;
        end else if (a >= ADDR_VRAM_LO && a <= ADDR_VRAM_HI) begin
          ans.fields.read_data = vl ? BYTE_ONES : mirror[a];
        end else if (a >= ADDR_ECHO_LO && a <= ADDR_ECHO_HI) begin
          ans.fields.read_data = mirror[a - ECHO_OFFSET];
        end else if (a >= ADDR_OAM_LO && a <= ADDR_OAM_HI) begin
          ans.fields.read_data = ol ? BYTE_ONES : mirror[a];
        end else if (a == REG_JOYP) begin
          ans.fields.read_data = mirror[a];
          // no button group selected reads as all released
          if ((mirror[a] & JOYP_SEL) == JOYP_SEL) ans.fields.read_data[3:0] = 4'hF;
        end else begin
          ans.fields.read_data = mirror[a];
        end
      end
      OP_PRELOAD: begin
        mirror[a] = d;
      end
      OP_WRITE: begin
        if (a <= ADDR_ROM_END) begin
          ans.target = TGT_CART_ROM;
        end else if (a >= ADDR_CRAM_LO && a <= ADDR_CRAM_HI) begin
          ans.target = TGT_CART_RAM;
        end else if (a >= ADDR_VRAM_LO && a <= ADDR_VRAM_HI) begin
          if (!vl) mirror[a] = d;
        end else if (a >= ADDR_ECHO_LO && a <= ADDR_ECHO_HI) begin
          mirror[a - ECHO_OFFSET] = d;
        end else if (a >= ADDR_OAM_LO && a <= ADDR_OAM_HI) begin
          if (!ol) mirror[a] = d;
        end else begin
          case (a)
            REG_JOYP: begin
              // low nibble follows the selected button group
              sel = d & JOYP_SEL;
              if (!sel[4]) low = pd;
              else if (!sel[5]) low = pa;
              else low = 4'hF;
              mirror[a] = (mirror[a] & JOYP_KEEP) | sel | {4'h0, low};
            end
            REG_SC:  mirror[a] = SC_FIXED | (d & SC_MASK);
            REG_DIV: begin
              mirror[a] = 8'h00;
              ans.fields.divider_reset = 1'b1;
            end
            REG_TAC: mirror[a] = TAC_FIXED | (d & TAC_MASK);
            REG_IF, REG_IE: mirror[a] = (mirror[a] & IRQ_KEEP) | (d & IRQ_MASK);
            REG_NR14, REG_NR24, REG_NR34, REG_NR44: begin
              mirror[a] = d & ~NRX4_UNUSED;
              case (a)
                REG_NR14: ans.fields.audio_channel = CH_1;
                REG_NR24: ans.fields.audio_channel = CH_2;
                REG_NR34: ans.fields.audio_channel = CH_3;
                default:  ans.fields.audio_channel = CH_4;
              endcase
              ans.fields.audio_trigger       = d[7];
              ans.fields.audio_length_enable = d[6];
            end
            REG_LCDC: begin
              mirror[a] = d;
              ans.fields.video_reset = ~d[7];
            end
            REG_DMA: begin
              ans.fields.dma_start = 1'b1;
              ans.fields.dma_page  = d;
            end
            REG_BOOT: begin
              // boot lock sticks once bit 0 is set
              if (!mirror[a][0]) mirror[a] = d;
            end
            default: mirror[a] = d;
          endcase
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  // answers are compared before the request of the same edge is predicted
  always @(posedge clk) begin
    answer_t want;
    result_t got;
    if (rst) begin
      mirror[REG_BOOT] = 8'h00;
      expected_answers.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata);
        if (expected_answers.size() == 0) begin
          fail_count++;
          $display("%0t: answer with no request waiting, expected none got %0h/%0h",
                   $time, m_tdata, m_tuser);
        end else begin
          want = expected_answers.pop_front();
          check_field("target", 8'(want.target), 8'(m_tuser));
          check_field("read_data", want.fields.read_data, got.read_data);
          check_field("audio_channel", 8'(want.fields.audio_channel), 8'(got.audio_channel));
          check_field("audio_trigger", 8'(want.fields.audio_trigger), 8'(got.audio_trigger));
          check_field("audio_length_enable", 8'(want.fields.audio_length_enable),
                      8'(got.audio_length_enable));
          check_field("dma_start", 8'(want.fields.dma_start), 8'(got.dma_start));
          check_field("dma_page", want.fields.dma_page, got.dma_page);
          check_field("divider_reset", 8'(want.fields.divider_reset), 8'(got.divider_reset));
          check_field("video_reset", 8'(want.fields.video_reset), 8'(got.video_reset));
        end
      end
      if (s_tvalid && s_tready)
        expected_answers.push_back(decode_access(op_t'(s_tuser), s_tdata[15:0],
                                                 s_tdata[23:16], s_tdata[24], s_tdata[25],
                                                 s_tdata[29:26], s_tdata[33:30]));
    end
    mismatches  <= fail_count;
    outstanding <= expected_answers.size();
  end

endmodule

// ===== tb/sv/tb_handheld_memory_bus_decoder.sv =====
`timescale 1ns / 1ps

module tb_handheld_memory_bus_decoder;
  import hmbd_pkg::*;

  localparam int RANDOM_REQUESTS = 921;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  int          mismatches;
  int          outstanding;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          cycle_count = 0;
  int          op_count [4] = '{default: 0};

  // which store bytes hold a known value, so reads never touch an unloaded one
  bit          written [0:65535];
  logic [15:0] written_list [$];
  logic [7:0]  boot_reg = 8'h00;

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  handheld_memory_bus_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  bus_decoder_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // result side back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d answers owed", cycle_count, outstanding);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void mark_written(input logic [15:0] a);
    if (!written[a]) begin
      written[a] = 1'b1;
      written_list.push_back(a);
    end
  endfunction

  // true when a read cannot land on an unloaded store byte
  function automatic bit read_is_safe(input logic [15:0] a, input logic vl, input logic ol);
    if (a <= ADDR_BOOT_END && !boot_reg[0]) return written[a];
    if (a <= ADDR_ROM_END) return 1'b1;
    if (a >= ADDR_CRAM_LO && a <= ADDR_CRAM_HI) return 1'b1;
    if (a >= ADDR_VRAM_LO && a <= ADDR_VRAM_HI) return vl || written[a];
    if (a >= ADDR_ECHO_LO && a <= ADDR_ECHO_HI) return written[a - ECHO_OFFSET];
    if (a >= ADDR_OAM_LO && a <= ADDR_OAM_HI) return ol || written[a];
    return written[a];
  endfunction

  // spread addresses over every area of the map, registers weighted up
  function automatic logic [15:0] pick_address();
    int area;
    area = $urandom_range(99);
    if (area < 5)  return 16'($urandom_range(ADDR_BOOT_END));
    if (area < 12) return 16'($urandom_range(ADDR_ROM_END, 16'h0100));
    if (area < 24) return 16'($urandom_range(ADDR_VRAM_HI, ADDR_VRAM_LO));
    if (area < 30) return 16'($urandom_range(ADDR_CRAM_HI, ADDR_CRAM_LO));
    if (area < 44) return 16'($urandom_range(16'hDFFF, 16'hC000));
    if (area < 54) return 16'($urandom_range(ADDR_ECHO_HI, ADDR_ECHO_LO));
    if (area < 64) return 16'($urandom_range(ADDR_OAM_HI, ADDR_OAM_LO));
    if (area < 84) begin
      case ($urandom_range(12))
        0:       return REG_JOYP;
        1:       return REG_SC;
        2:       return REG_DIV;
        3:       return REG_TAC;
        4:       return REG_IF;
        5:       return REG_NR14;
        6:       return REG_NR24;
        7:       return REG_NR34;
        8:       return REG_NR44;
        9:       return REG_LCDC;
        10:      return REG_DMA;
        11:      return REG_BOOT;
        default: return REG_IE;
      endcase
    end
    if (area < 90) return 16'($urandom_range(16'hFF7F, 16'hFF01));
    if (area < 98) return 16'($urandom_range(16'hFFFE, 16'hFF80));
    return REG_IE;
  endfunction

  // hand one request over and track what it leaves in the store
  task automatic send_request(input op_t op, input logic [15:0] a, input logic [7:0] d,
                              input logic vl, input logic ol, input logic [3:0] pd,
                              input logic [3:0] pa);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, pa, pd, ol, vl, d, a};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    op_count[int'(op)]++;
    case (op)
      OP_PRELOAD: begin
        mark_written(a);
        if (a == REG_BOOT) boot_reg = d;
      end
      OP_WRITE: begin
        if (a >= ADDR_VRAM_LO && a <= ADDR_VRAM_HI) begin
          if (!vl) mark_written(a);
        end else if (a >= ADDR_ECHO_LO && a <= ADDR_ECHO_HI) begin
          mark_written(a - ECHO_OFFSET);
        end else if (a >= ADDR_OAM_LO && a <= ADDR_OAM_HI) begin
          if (!ol) mark_written(a);
        end else if (a == REG_BOOT) begin
          if (!boot_reg[0]) boot_reg = d;
        end else if (a > ADDR_ROM_END && !(a >= ADDR_CRAM_LO && a <= ADDR_CRAM_HI) &&
                     a != REG_DMA) begin
          mark_written(a);
        end
      end
      default: ;
    endcase
  endtask

  // stimulus
  initial begin
    logic [15:0] a;
    logic        vl;
    logic        ol;
    int          roll;
    int          tries;

    written[REG_BOOT] = 1'b1;
    written_list.push_back(REG_BOOT);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: map extremes, every register rule and the special cases
    send_request(OP_PRELOAD, REG_JOYP, 8'hF0, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_PRELOAD, REG_IF,   8'hE0, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_PRELOAD, REG_IE,   8'hFF, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_PRELOAD, 16'h0000, 8'h31, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_READ,    16'h0000, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_READ,    ADDR_ROM_END, 8'h00, 1'b0, 1'b0, 4'hF, 4'hF);
    send_request(OP_READ,    ADDR_CRAM_HI, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_WRITE,   ADDR_CRAM_LO, 8'h55, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_WRITE,   ADDR_VRAM_LO, 8'h3C, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_READ,    ADDR_VRAM_LO, 8'h00, 1'b1, 1'b0, 4'h0, 4'h0);
    send_request(OP_WRITE,   ADDR_ECHO_HI, 8'h77, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_READ,    ADDR_ECHO_HI, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_WRITE,   ADDR_OAM_HI,  8'h99, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_READ,    ADDR_OAM_HI,  8'h00, 1'b0, 1'b1, 4'h0, 4'h0);
    send_request(OP_READ,    REG_JOYP, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_WRITE,   REG_JOYP, 8'h20, 1'b0, 1'b0, 4'hA, 4'h5);
    send_request(OP_WRITE,   REG_JOYP, 8'h10, 1'b0, 1'b0, 4'hA, 4'h5);
    send_request(OP_WRITE,   REG_SC,   8'hFF, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_WRITE,   REG_DIV,  8'hAB, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_WRITE,   REG_TAC,  8'hFF, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_WRITE,   REG_IF,   8'hFF, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_WRITE,   REG_NR14, 8'hFF, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_WRITE,   REG_NR34, 8'h40, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_WRITE,   REG_LCDC, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_WRITE,   REG_DMA,  8'hFF, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_WRITE,   REG_BOOT, 8'h01, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_READ,    16'h0000, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
    send_request(OP_NONE,    16'hFFFF, 8'hFF, 1'b1, 1'b1, 4'hF, 4'hF);

    // random traffic in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 30; recv_idle_pct = 73; end
        1:       begin send_idle_pct = 73; recv_idle_pct = 30; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int n = 0; n < RANDOM_REQUESTS / 3; n++) begin
        roll = $urandom_range(99);
        vl   = ($urandom_range(3) == 0);
        ol   = ($urandom_range(3) == 0);
        if (roll < 40) begin
          // reads mostly go back to loaded bytes, sometimes through the echo window
          tries = 0;
          do begin
            if ($urandom_range(99) < 60) begin
              a = written_list[$urandom_range(written_list.size() - 1)];
              if (a >= 16'hC000 && a <= 16'hDDFF && $urandom_range(3) == 0)
                a = a + ECHO_OFFSET;
            end else begin
              a = pick_address();
            end
            tries++;
          end while (!read_is_safe(a, vl, ol) && tries < 8);
          if (!read_is_safe(a, vl, ol)) a = REG_BOOT;
          send_request(OP_READ, a, 8'($urandom), vl, ol, 4'($urandom), 4'($urandom));
        end else if (roll < 75) begin
          send_request(OP_WRITE, pick_address(), 8'($urandom), vl, ol,
                       4'($urandom), 4'($urandom));
        end else if (roll < 97) begin
          send_request(OP_PRELOAD, pick_address(), 8'($urandom), vl, ol,
                       4'($urandom), 4'($urandom));
        end else begin
          send_request(OP_NONE, 16'($urandom), 8'($urandom), vl, ol,
                       4'($urandom), 4'($urandom));
        end
      end
    end

    // drain
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("requests: %0d reads, %0d decoded writes, %0d preloads, %0d unused op codes",
             op_count[int'(OP_READ)], op_count[int'(OP_WRITE)],
             op_count[int'(OP_PRELOAD)], op_count[int'(OP_NONE)]);
    $display("%0d distinct store bytes loaded, %0d mismatches seen",
             written_list.size(), mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
